[design/ssm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the stripe sector mapper.
// Used by every module of the block; depends on nothing.
package ssm_pkg;

  localparam int MaxStripes = 16;
  localparam int SectorBits = 48;
  localparam int ChunkBits  = 32;
  localparam int StripeBits = 4;
  localparam int CountBits  = 5;
  localparam int NumCells   = SectorBits;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_MAP,
    KIND_RANGE,
    KIND_FLUSH
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_MISS,
    STAT_BAD,
    STAT_LOADED
  } status_e;

  typedef enum logic [1:0] {
    CFG_CHUNK,
    CFG_COUNT,
    CFG_BEGIN,
    CFG_NONE
  } cfg_idx_e;

  typedef struct packed {
    kind_e                  kind;
    logic [SectorBits-1:0]  sector;
    logic [SectorBits-1:0]  end_sector;
    logic [StripeBits-1:0]  stripe_select;
  } in_word_t;

  typedef struct packed {
    logic [StripeBits-1:0]  stripe_out;
    logic [SectorBits-1:0]  device_sector;
    logic [SectorBits-1:0]  length_sectors;
    status_e                status;
  } out_word_t;

  // effective chunk size and stripe count
  typedef struct packed {
    logic [ChunkBits-1:0]  cs;
    logic [CountBits-1:0]  n;
  } cfg_t;

  // one endpoint on its way through the divider chain; acc builds
  // (chunk / count) * chunk size one quotient bit at a time
  typedef struct packed {
    logic [SectorBits-1:0]  rel;
    logic [SectorBits-1:0]  dvd;
    logic [ChunkBits-1:0]   rem;
    logic [StripeBits-1:0]  res;
    logic [SectorBits-1:0]  acc;
  } lane_t;

  typedef struct packed {
    kind_e                  kind;
    logic [StripeBits-1:0]  sel;
    lane_t                  a;
    lane_t                  b;
  } item_t;

endpackage

[design/stripe_sector_mapper_top.sv]
`timescale 1ns / 1ps
// Stripe sector mapper top: config registers, input stage, 48 divider cells
// and the back end. Depends on ssm_pkg, ssm_cell and ssm_tail.
// Word path: input stage, one cell per quotient bit of the 48-bit offset,
// then the sum stage and the output register.
// Throughput: one word per cycle; each stage holds its word under stall.
// Reset: async active low, clears all valid bits and loads config defaults;
// the stripe base table is not cleared and must be loaded before use.
module stripe_sector_mapper_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  ssm_pkg::in_word_t               in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output ssm_pkg::out_word_t              out_word_o,
  input  logic                            cfg_we_i,
  input  ssm_pkg::cfg_idx_e               cfg_index_i,
  input  logic [ssm_pkg::SectorBits-1:0]  cfg_data_i
);

  localparam int NC = ssm_pkg::NumCells;

  logic [ssm_pkg::ChunkBits-1:0]   chunk_q;
  logic [ssm_pkg::CountBits-1:0]   count_q;
  logic [ssm_pkg::SectorBits-1:0]  begin_q;
  ssm_pkg::cfg_t                   cfg;

  logic                            v0_q;
  ssm_pkg::item_t                  item0_d, item0_q;
  logic [NC:0]                     vld;
  logic [NC:0]                     rdy;
  ssm_pkg::item_t                  itm [NC+1];
  logic                            in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= ssm_pkg::ChunkBits'(8);
      count_q <= ssm_pkg::CountBits'(1);
      begin_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ssm_pkg::CFG_CHUNK: chunk_q <= cfg_data_i[ssm_pkg::ChunkBits-1:0];
        ssm_pkg::CFG_COUNT: count_q <= cfg_data_i[ssm_pkg::CountBits-1:0];
        ssm_pkg::CFG_BEGIN: begin_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero chunk acts as one; count clamps to 1..MaxStripes
  always_comb begin
    cfg.cs = (chunk_q == '0) ? ssm_pkg::ChunkBits'(1) : chunk_q;
    if (count_q == '0) begin
      cfg.n = ssm_pkg::CountBits'(1);
    end else if (count_q > ssm_pkg::CountBits'(ssm_pkg::MaxStripes)) begin
      cfg.n = ssm_pkg::CountBits'(ssm_pkg::MaxStripes);
    end else begin
      cfg.n = count_q;
    end
  end

  always_comb begin
    item0_d.kind  = in_word_i.kind;
    item0_d.sel   = in_word_i.stripe_select;
    item0_d.a.rel = in_word_i.sector - begin_q;
    item0_d.a.dvd = in_word_i.sector - begin_q;
    item0_d.a.rem = '0;
    item0_d.a.res = '0;
    item0_d.a.acc = '0;
    item0_d.b.rel = in_word_i.end_sector - begin_q;
    item0_d.b.dvd = in_word_i.end_sector - begin_q;
    item0_d.b.rem = '0;
    item0_d.b.res = '0;
    item0_d.b.acc = '0;
  end

  assign in_ready   = !v0_q || rdy[0];
  assign in_stall_o = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (in_ready) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      item0_q <= item0_d;
    end
  end

  assign vld[0] = v0_q;
  assign itm[0] = item0_q;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    ssm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cfg_i   (cfg),
      .valid_i (vld[k]),
      .item_i  (itm[k]),
      .ready_i (rdy[k+1]),
      .ready_o (rdy[k]),
      .valid_o (vld[k+1]),
      .item_o  (itm[k+1])
    );
  end

  ssm_tail u_tail (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .begin_i     (begin_q),
    .valid_i     (vld[NC]),
    .item_i      (itm[NC]),
    .ready_o     (rdy[NC]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  a_load_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == ssm_pkg::STAT_LOADED |->
      out_word_o.device_sector == '0 && out_word_o.length_sectors == '0)
    else $error("load result carries nonzero sector or length");

  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v0_q)
    else $error("accepted word missing from input stage");

  a_tail_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[NC] && !rdy[NC] |=> vld[NC])
    else $error("word dropped at the end of the cell chain");

endmodule

[design/ssm_cell.sv]
`timescale 1ns / 1ps
// One divider cell: a restoring step by the chunk size, a running residue
// of the quotient modulo the stripe count and the scaled stripe quotient.
// Depends on ssm_pkg.
module ssm_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ssm_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  input  ssm_pkg::item_t item_i,
  input  logic           ready_i,
  output logic           ready_o,
  output logic           valid_o,
  output ssm_pkg::item_t item_o
);

  function automatic ssm_pkg::lane_t step(ssm_pkg::lane_t l, ssm_pkg::cfg_t c);
    ssm_pkg::lane_t                 o;
    logic [ssm_pkg::ChunkBits:0]    r2;
    logic [ssm_pkg::CountBits-1:0]  s2;
    logic                           q;
    logic                           qn;
    o  = l;
    r2 = {l.rem, l.dvd[ssm_pkg::SectorBits-1]};
    if (r2 >= {1'b0, c.cs}) begin
      r2 = r2 - {1'b0, c.cs};
      q  = 1'b1;
    end else begin
      q  = 1'b0;
    end
    o.rem = r2[ssm_pkg::ChunkBits-1:0];
    o.dvd = {l.dvd[ssm_pkg::SectorBits-2:0], 1'b0};
    // residue stays below the count, so one subtract suffices
    s2 = {l.res, q};
    if (s2 >= c.n) begin
      s2 = s2 - c.n;
      qn = 1'b1;
    end else begin
      qn = 1'b0;
    end
    o.res = s2[ssm_pkg::StripeBits-1:0];
    // shift in the next quotient bit of chunk / count, scaled by chunk size
    o.acc = {l.acc[ssm_pkg::SectorBits-2:0], 1'b0} +
            (qn ? ssm_pkg::SectorBits'(c.cs) : '0);
    return o;
  endfunction

  logic           valid_q;
  ssm_pkg::item_t item_q, item_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_comb begin
    item_d   = item_i;
    item_d.a = step(item_i.a, cfg_i);
    item_d.b = step(item_i.b, cfg_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

[design/ssm_tail.sv]
`timescale 1ns / 1ps
// Back end: sector within the stripe, endpoint clipping, stripe base table
// and the output register. Depends on ssm_pkg.
module ssm_tail (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ssm_pkg::cfg_t                       cfg_i,
  input  logic [ssm_pkg::SectorBits-1:0]      begin_i,
  input  logic                                valid_i,
  input  ssm_pkg::item_t                      item_i,
  output logic                                ready_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ssm_pkg::out_word_t                  out_word_o
);

  localparam int WideBits = ssm_pkg::SectorBits + 1;

  typedef struct packed {
    logic [ssm_pkg::SectorBits-1:0]  rel;
    logic [ssm_pkg::ChunkBits-1:0]   off;
    logic [ssm_pkg::StripeBits-1:0]  res;
    logic [ssm_pkg::SectorBits-1:0]  dev;
  } tlane_t;

  function automatic logic [WideBits-1:0] clip(tlane_t l,
                                               logic [ssm_pkg::StripeBits-1:0] sel,
                                               logic [ssm_pkg::ChunkBits-1:0] cs);
    logic [ssm_pkg::SectorBits-1:0] d;
    logic [WideBits-1:0]            r;
    d = l.dev;
    if (l.res == sel) begin
      r = {1'b0, d};
    end else begin
      r = {1'b0, d - ssm_pkg::SectorBits'(l.off)};
      if (sel < l.res) begin
        r = r + WideBits'(cs);
      end
    end
    return r;
  endfunction

  logic                            v1_q;
  ssm_pkg::kind_e                  kind_q;
  logic [ssm_pkg::StripeBits-1:0]  sel_q;
  tlane_t                          la_q, lb_q;
  logic                            ready2;

  logic                            out_valid_q;
  ssm_pkg::out_word_t              out_q, out_d;

  logic [ssm_pkg::SectorBits-1:0]  base_q [ssm_pkg::MaxStripes];
  logic [ssm_pkg::StripeBits-1:0]  base_addr;
  logic [ssm_pkg::SectorBits-1:0]  base_rd;
  logic                            base_we;

  logic [ssm_pkg::SectorBits-1:0]  d_a;
  logic [WideBits-1:0]             b_w, e_w, dev_w;
  logic                            bad_sel;

  assign ready2  = !out_valid_q || !out_stall_i;
  assign ready_o = !v1_q || ready2;

  // stage 1: add the in-chunk offset to the scaled stripe quotient
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ready_o) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      kind_q     <= item_i.kind;
      sel_q      <= item_i.sel;
      la_q.rel   <= item_i.a.rel;
      la_q.off   <= item_i.a.rem;
      la_q.res   <= item_i.a.res;
      la_q.dev   <= item_i.a.acc + ssm_pkg::SectorBits'(item_i.a.rem);
      lb_q.rel   <= item_i.b.rel;
      lb_q.off   <= item_i.b.rem;
      lb_q.res   <= item_i.b.res;
      lb_q.dev   <= item_i.b.acc + ssm_pkg::SectorBits'(item_i.b.rem);
    end
  end

  // stage 2: finish and register the result word
  assign base_addr = (kind_q == ssm_pkg::KIND_MAP) ? la_q.res : sel_q;
  assign base_rd   = base_q[base_addr];
  assign base_we   = v1_q && ready2 && (kind_q == ssm_pkg::KIND_LOAD);

  always_comb begin
    d_a     = la_q.dev;
    b_w     = clip(la_q, sel_q, cfg_i.cs);
    e_w     = clip(lb_q, sel_q, cfg_i.cs);
    dev_w   = b_w + {1'b0, base_rd};
    bad_sel = {1'b0, sel_q} >= cfg_i.n;

    out_d                = '0;
    out_d.stripe_out     = sel_q;
    case (kind_q)
      ssm_pkg::KIND_LOAD: begin
        out_d.status = ssm_pkg::STAT_LOADED;
      end
      ssm_pkg::KIND_MAP: begin
        out_d.stripe_out    = la_q.res;
        out_d.device_sector = d_a + base_rd;
        out_d.status        = ssm_pkg::STAT_OK;
      end
      ssm_pkg::KIND_RANGE: begin
        if (bad_sel) begin
          out_d.status = ssm_pkg::STAT_BAD;
        end else if (b_w < e_w) begin
          out_d.device_sector  = dev_w[ssm_pkg::SectorBits-1:0];
          out_d.length_sectors = ssm_pkg::SectorBits'(e_w - b_w);
          out_d.status         = ssm_pkg::STAT_OK;
        end else begin
          out_d.status = ssm_pkg::STAT_MISS;
        end
      end
      ssm_pkg::KIND_FLUSH: begin
        out_d.status = bad_sel ? ssm_pkg::STAT_BAD : ssm_pkg::STAT_OK;
      end
      default: begin
        out_d.status = ssm_pkg::STAT_BAD;
      end
    endcase
  end

  // loads land here so they stay in order with the reads
  always_ff @(posedge clk_i) begin
    if (base_we) begin
      base_q[sel_q] <= la_q.rel + begin_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready2) begin
      out_valid_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready2 && v1_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the stripe sector mapper: a directed table, then
// random bursts over several register settings, checked by an inline predictor.
// Depends on ssm_pkg and stripe_sector_mapper_top.
module testbench;
  import ssm_pkg::*;

  localparam longint unsigned SectorMask = 64'h0000_FFFF_FFFF_FFFF;
  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 60;
  localparam int ItemsPerSetting = 230;
  localparam int NumSettings = 7;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t res;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic      cfg_we = 1'b0;
  cfg_idx_e  cfg_index = CFG_CHUNK;
  logic [SectorBits-1:0] cfg_data = '0;

  // mapper state as the testbench sees it
  longint unsigned chunk_reg, count_reg, begin_reg;
  logic [SectorBits-1:0] base_tab [MaxStripes];

  out_word_t pending_q[$];
  dir_row_t  dir_tab[$];
  int        mismatches = 0;
  int        cycles = 0;
  bit        hold_req = 1'b0;

  stripe_sector_mapper_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint unsigned eff_chunk();
    return (chunk_reg == 0) ? 64'd1 : chunk_reg;
  endfunction

  function automatic longint unsigned eff_count();
    if (count_reg == 0) return 1;
    if (count_reg > MaxStripes) return MaxStripes;
    return count_reg;
  endfunction

  function automatic void split_sector(input longint unsigned sec,
                                       output longint unsigned stripe,
                                       output longint unsigned dev);
    longint unsigned cs, n, rel, chunk;
    cs = eff_chunk();
    n = eff_count();
    rel = (sec - begin_reg) & SectorMask;
    chunk = rel / cs;
    stripe = chunk % n;
    dev = (chunk / n) * cs + rel % cs;
  endfunction

  // round a range endpoint onto the chunk grid of stripe tgt
  function automatic longint unsigned clip_end(longint unsigned sec, longint unsigned tgt);
    longint unsigned s, d, r, t, cs;
    cs = eff_chunk();
    split_sector(sec, s, d);
    if (s == tgt) return d;
    r = d - (d % cs);
    if (tgt < s) begin
      t = r + cs;
      r = (t < r) ? 64'hFFFF_FFFF_FFFF_FFFF : t;
    end
    return r;
  endfunction

  function automatic out_word_t map_word(in_word_t w);
    out_word_t o;
    longint unsigned st, dev, b, e;
    o = '0;
    o.stripe_out = w.stripe_select;
    case (w.kind)
      KIND_LOAD: begin
        base_tab[w.stripe_select] = w.sector;
        o.status = STAT_LOADED;
      end
      KIND_MAP: begin
        split_sector(w.sector, st, dev);
        o.stripe_out = st[StripeBits-1:0];
        o.device_sector = SectorBits'((dev + base_tab[st]) & SectorMask);
        o.status = STAT_OK;
      end
      default: begin
        if (w.stripe_select >= eff_count()) begin
          o.status = STAT_BAD;
        end else if (w.kind == KIND_RANGE) begin
          b = clip_end(w.sector, w.stripe_select);
          e = clip_end(w.end_sector, w.stripe_select);
          if (b < e) begin
            o.device_sector = SectorBits'((b + base_tab[w.stripe_select]) & SectorMask);
            o.length_sectors = SectorBits'((e - b) & SectorMask);
            o.status = STAT_OK;
          end else begin
            o.status = STAT_MISS;
          end
        end else begin
          o.status = STAT_OK;
        end
      end
    endcase
    return o;
  endfunction

  // drive one word and hold it until accepted
  task automatic send_word(in_word_t w, bit typed, out_word_t res);
    out_word_t pred;
    @(negedge clk);
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    pred = map_word(w);
    pending_q.push_back(typed ? res : pred);
  endtask

  task automatic idle_gap(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [SectorBits-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CHUNK: chunk_reg = val[ChunkBits-1:0];
      CFG_COUNT: count_reg = val[CountBits-1:0];
      CFG_BEGIN: begin_reg = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    idle_gap(1);
    wait (pending_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // mostly near the target begin so ranges land on stripes; else anywhere
  function automatic logic [SectorBits-1:0] pick_sector();
    longint unsigned span;
    if ($urandom_range(0, 3) == 0) return SectorBits'({$urandom, $urandom});
    span = eff_chunk() * eff_count() * $urandom_range(1, 6);
    return SectorBits'(begin_reg + ({$urandom, $urandom} % (span + 1)));
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int pick;
    longint unsigned span;
    pick = $urandom_range(0, 99);
    w.kind = (pick < 10) ? KIND_LOAD : (pick < 50) ? KIND_MAP :
             (pick < 85) ? KIND_RANGE : KIND_FLUSH;
    w.sector = (w.kind == KIND_LOAD) ? SectorBits'({$urandom, $urandom}) : pick_sector();
    span = eff_chunk() * $urandom_range(0, 3 * eff_count()) + $urandom_range(0, 9);
    case ($urandom_range(0, 3))
      0: w.end_sector = SectorBits'({$urandom, $urandom});
      1: w.end_sector = pick_sector();
      default: w.end_sector = SectorBits'(w.sector + span);
    endcase
    if (w.kind == KIND_LOAD || $urandom_range(0, 5) == 0)
      w.stripe_select = StripeBits'($urandom_range(0, MaxStripes - 1));
    else
      w.stripe_select = StripeBits'($urandom_range(0, eff_count() - 1));
    return w;
  endfunction

  task automatic add_row(kind_e k, longint unsigned s, longint unsigned e, int sel,
                         bit typed, out_word_t res);
    dir_row_t r;
    r.w = '{kind: k, sector: s[SectorBits-1:0], end_sector: e[SectorBits-1:0],
            stripe_select: sel[StripeBits-1:0]};
    r.typed = typed;
    r.res = res;
    dir_tab.push_back(r);
  endtask

  // receiver: stall pattern changes per stretch; a requested hold-off wins
  initial begin
    int mode, len;
    forever begin
      mode = $urandom_range(0, 2);
      len = $urandom_range(20, 200);
      if (hold_req) begin
        repeat (400) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
        hold_req = 1'b0;
      end else begin
        for (int i = 0; i < len; i++) begin
          @(negedge clk);
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 9) < 3);
            default: out_stall <= (i % 3 == 2);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    out_word_t exp_w;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", out_word);
      end else begin
        exp_w = pending_q.pop_front();
        if (out_word !== exp_w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp stripe %0d dev %h len %h status %s, got %0d %h %h %s",
                     exp_w.stripe_out, exp_w.device_sector, exp_w.length_sectors,
                     exp_w.status.name(), out_word.stripe_out, out_word.device_sector,
                     out_word.length_sectors, out_word.status.name());
        end
      end
    end
  end

  initial begin
    longint unsigned chunk_set [NumSettings] = '{1, 64'hFFFF_FFFF, 0, 16, 3, 4096, 7};
    longint unsigned count_set [NumSettings] = '{16, 16, 0, 31, 5, 7, 16};
    longint unsigned begin_set [NumSettings] = '{0, SectorMask, 12345, 0, 0, 0, 0};
    int burst, sent;
    out_word_t none;
    none = '0;

    chunk_reg = 8;
    count_reg = 1;
    begin_reg = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // fill the whole base table first so no read hits an unwritten entry
    for (int i = 0; i < MaxStripes; i++)
      add_row(KIND_LOAD, (i == 0) ? 0 : (i == 1) ? SectorMask : i * 64'h1_0001_0000, 0, i,
              1'b1, '{stripe_out: StripeBits'(i), device_sector: 0, length_sectors: 0,
                      status: STAT_LOADED});
    add_row(KIND_MAP, 0, 0, 0, 1'b1,
            '{stripe_out: 0, device_sector: 0, length_sectors: 0, status: STAT_OK});
    add_row(KIND_MAP, SectorMask, 0, 15, 1'b0, none);
    add_row(KIND_MAP, 64'h8000_0000_0001, 0, 3, 1'b0, none);
    add_row(KIND_RANGE, 0, SectorMask, 0, 1'b0, none);
    add_row(KIND_RANGE, 100, 50, 0, 1'b1,
            '{stripe_out: 0, device_sector: 0, length_sectors: 0, status: STAT_MISS});
    add_row(KIND_RANGE, 0, 64, 5, 1'b1,
            '{stripe_out: 5, device_sector: 0, length_sectors: 0, status: STAT_BAD});
    add_row(KIND_FLUSH, SectorMask, SectorMask, 0, 1'b1,
            '{stripe_out: 0, device_sector: 0, length_sectors: 0, status: STAT_OK});
    add_row(KIND_FLUSH, 0, 0, 15, 1'b1,
            '{stripe_out: 15, device_sector: 0, length_sectors: 0, status: STAT_BAD});
    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].res);

    for (int p = 0; p < NumSettings; p++) begin
      wait_idle();
      write_reg(CFG_CHUNK, chunk_set[p][SectorBits-1:0]);
      write_reg(CFG_COUNT, count_set[p][SectorBits-1:0]);
      write_reg(CFG_BEGIN, SectorBits'((p >= 3) ? {$urandom, $urandom} : begin_set[p]));
      if (p == 2) hold_req = 1'b1;
      sent = 0;
      while (sent < ItemsPerSetting) begin
        burst = $urandom_range(1, 24);
        for (int i = 0; i < burst; i++) send_word(random_word(), 1'b0, none);
        sent += burst;
        if (p == 4 && sent >= ItemsPerSetting / 2 && sent < ItemsPerSetting / 2 + burst) begin
          idle_gap(1);
          wait (pending_q.size() == 0);
        end else if ($urandom_range(0, 3) != 0) begin
          idle_gap($urandom_range(1, 10));
        end
      end
    end

    idle_gap(1);
    wait (pending_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
